// ----- hdl/dipolar_rotor_metropolis_update_macros.svh -----
// Assertion macros for the dipolar rotor Metropolis update block.
// Used by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef DIPOLAR_ROTOR_METROPOLIS_UPDATE_MACROS_SVH
`define DIPOLAR_ROTOR_METROPOLIS_UPDATE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DRMU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("drmu: same-cycle check failed");
// next-cycle implication
`define DRMU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("drmu: next-cycle check failed");
`else
`define DRMU_ASSERT_NOW(lbl, ante, cons)
`define DRMU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/drmu_pkg.sv -----
// Shared types and constants for the dipolar rotor Metropolis update block.
// No dependencies.
`default_nettype none
package drmu_pkg;

    localparam int SITES       = 64;
    localparam int SITE_W      = 6;
    localparam int LEN_W       = 7;
    localparam int ANG_W       = 16;
    localparam int COEF_W      = 32;
    localparam int ACC_W       = 40;
    localparam int TERM_W      = 26;
    localparam int TRIG_STAGES = 4;
    localparam int TERM_STAGES = 3;

    localparam logic [LEN_W-1:0] LEN_MIN = 7'd2;
    localparam logic [LEN_W-1:0] LEN_MAX = 7'd64;
    localparam logic [ANG_W-1:0] QUARTER = 16'h4000;

    // function codes
    localparam logic [1:0] FUNC_LOAD_ANGLE = 2'd0;
    localparam logic [1:0] FUNC_LOAD_COEFF = 2'd1;
    localparam logic [1:0] FUNC_MOVE       = 2'd2;

    // register indexes
    localparam logic CFG_INV_TEMP = 1'b0;
    localparam logic CFG_RING_LEN = 1'b1;

    // sine polynomial, Q30
    localparam logic [30:0] SIN_A = 31'd1686629713;
    localparam logic [29:0] SIN_B = 30'd688904866;
    localparam logic [26:0] SIN_C = 27'd76016977;

    // 2^-f quartic, Q30
    localparam logic [30:0] EXP_ONE  = 31'd1073741824;
    localparam logic [30:0] EXP_A    = 31'd744261118;
    localparam logic [30:0] EXP_B    = 31'd257941248;
    localparam logic [30:0] EXP_C    = 31'd59597083;
    localparam logic [30:0] EXP_D    = 31'd9046041;
    localparam logic [16:0] LOG2E    = 17'd94548;
    localparam logic [34:0] EXP_XMAX = 35'd786432;

    typedef enum logic [2:0] {
        EXP_MUL_BETA = 3'd0,
        EXP_LOG2     = 3'd1,
        EXP_P1       = 3'd2,
        EXP_P2       = 3'd3,
        EXP_P3       = 3'd4,
        EXP_P4       = 3'd5,
        EXP_FINAL    = 3'd6
    } exp_step_t;

    typedef struct packed {
        logic [1:0]               func;
        logic                     sublattice;
        logic [SITE_W-1:0]        site;
        logic [ANG_W-1:0]         angle;
        logic signed [15:0]       delta;
        logic [15:0]              uniform;
        logic [SITE_W-1:0]        coeff_index;
        logic signed [COEF_W-1:0] coeff_same;
        logic signed [COEF_W-1:0] coeff_cross_z;
        logic signed [COEF_W-1:0] coeff_cross_x;
    } in_item_t;

    typedef struct packed {
        logic               accepted;
        logic [ANG_W-1:0]   new_angle;
        logic signed [31:0] energy_change;
    } out_item_t;

    typedef struct packed {
        logic              capture;
        logic              issue;
        logic              latch;
        logic              pre;
        logic              sweep;
        logic [SITE_W-1:0] idx;
        logic              exp_en;
        exp_step_t         exp_step;
        logic              wb;
        logic              load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic run_move;
        logic pipe_busy;
        logic sweep_last;
        logic idx_ok;
    } ctrl_sts_t;

endpackage
`default_nettype wire

// ----- hdl/dipolar_rotor_metropolis_update.sv -----
// Metropolis move engine for two periodic rings of dipolar rotors. Software
// loads rotor angles (func 0) and coupling entries (func 1) one beat at a time.
// A move (func 2) reads the rotor, evaluates the old and new cos/sin, then
// sweeps all L sites (L = ring_length clamped to 2..64) at one site per
// cycle through four pipelined sine lanes and four bond-term multipliers,
// accumulates dE, runs a seven-step exp unit and writes back on acceptance.
// One result beat follows every input beat; the next beat is taken while a
// finished result waits in the output register. Memory contents are
// undefined until loaded. Depends on drmu_pkg, drmu_ctrl and drmu_datapath.
`default_nettype none
module dipolar_rotor_metropolis_update (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  drmu_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output drmu_pkg::out_item_t result,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data
);

    drmu_pkg::ctrl_cmd_t cmd;
    drmu_pkg::ctrl_sts_t sts;

    // sequencer
    drmu_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    // arithmetic and storage
    drmu_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .result    (result)
    );

endmodule
`default_nettype wire

// ----- hdl/drmu_sin.sv -----
// Four-stage pipelined Q1.15 sine of a 16-bit turn fraction.
// Depends on drmu_pkg for the polynomial constants.
`default_nettype none
module drmu_sin (
    input  logic               clk,
    input  logic [15:0]        phase,
    output logic signed [15:0] sin_q15
);

    logic signed [17:0] s_c, sf_c, mag_c;
    logic [14:0]        x_c;
    logic [29:0]        sq_c;

    logic [14:0]        s1_x_reg, s1_x2_reg;
    logic               s1_neg_reg;
    logic [14:0]        s2_x_reg, s2_x2_reg;
    logic               s2_neg_reg;
    logic [29:0]        s2_t1_reg;
    logic [14:0]        s3_x_reg;
    logic               s3_neg_reg;
    logic [30:0]        s3_t2_reg;
    logic signed [15:0] out_reg;

    logic [41:0] m2_c;
    logic [44:0] m3_c;
    logic [46:0] m4_c;
    logic [17:0] r_c;
    logic [14:0] rc_c;

    // fold into [-quarter, +quarter] and square
    always_comb
    begin
        s_c = $signed({{2{phase[15]}}, phase});
        if (s_c > 18'sd16384)
        begin
            sf_c = 18'sd32768 - s_c;
        end
        else if (s_c < -18'sd16384)
        begin
            sf_c = -18'sd32768 - s_c;
        end
        else
        begin
            sf_c = s_c;
        end
        mag_c = sf_c[17] ? -sf_c : sf_c;
        x_c   = mag_c[14:0];
        sq_c  = 30'(x_c) * 30'(x_c);
    end

    // polynomial terms
    always_comb
    begin
        m2_c = 42'(drmu_pkg::SIN_C) * 42'(s1_x2_reg);
        m3_c = 45'(s2_t1_reg) * 45'(s2_x2_reg);
        m4_c = 47'(s3_t2_reg) * 47'(s3_x_reg) + 47'd268435456;
        r_c  = m4_c[46:29];
        rc_c = (r_c > 18'd32767) ? 15'h7fff : r_c[14:0];
    end

    always_ff @(posedge clk)
    begin
        s1_x_reg   <= x_c;
        s1_neg_reg <= sf_c[17];
        s1_x2_reg  <= sq_c[28:14];

        s2_x_reg   <= s1_x_reg;
        s2_neg_reg <= s1_neg_reg;
        s2_x2_reg  <= s1_x2_reg;
        s2_t1_reg  <= drmu_pkg::SIN_B - 30'(m2_c >> 14);

        s3_x_reg   <= s2_x_reg;
        s3_neg_reg <= s2_neg_reg;
        s3_t2_reg  <= drmu_pkg::SIN_A - 31'(m3_c >> 14);

        out_reg    <= s3_neg_reg ? -$signed({1'b0, rc_c}) : $signed({1'b0, rc_c});
    end

    assign sin_q15 = out_reg;

endmodule
`default_nettype wire

// ----- hdl/drmu_term.sv -----
// Three-stage bond term: round(round(u*v, Q15) * k, Q20), sign-magnitude.
// Depends on drmu_pkg for the term width.
`default_nettype none
module drmu_term (
    input  logic                              clk,
    input  logic signed [16:0]                u,
    input  logic signed [15:0]                v,
    input  logic signed [31:0]                k,
    output logic signed [drmu_pkg::TERM_W-1:0] t
);

    logic signed [32:0] p_reg;
    logic signed [31:0] k_reg;
    logic [48:0]        prod_reg;
    logic               neg_reg;
    logic signed [drmu_pkg::TERM_W-1:0] t_reg;

    logic [32:0] pm_c, pr_c;
    logic [16:0] pq_c;
    logic [31:0] km_c;
    logic [48:0] mr_c;
    logic [24:0] m_c;

    always_comb
    begin
        pm_c = p_reg[32] ? 33'(-p_reg) : 33'(p_reg);
        pr_c = 33'(pm_c[31:0]) + 33'd16384;
        pq_c = pr_c[31:15];
        km_c = k_reg[31] ? 32'(-k_reg) : 32'(k_reg);
        mr_c = prod_reg + 49'd4194304;
        m_c  = mr_c[47:23];
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= 33'(u) * 33'(v);
        k_reg    <= k;
        prod_reg <= 49'(pq_c) * 49'(km_c);
        neg_reg  <= p_reg[32] ^ k_reg[31];
        t_reg    <= neg_reg ? -$signed({1'b0, m_c}) : $signed({1'b0, m_c});
    end

    assign t = t_reg;

endmodule
`default_nettype wire

// ----- hdl/drmu_datapath.sv -----
// Datapath: angle and coupling memories, trig and term pipelines, accumulator,
// exp unit and result register. Depends on drmu_pkg, drmu_sin, drmu_term.
`default_nettype none
module drmu_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  drmu_pkg::in_item_t    item,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [15:0]           cfg_data,
    input  drmu_pkg::ctrl_cmd_t   cmd,
    output drmu_pkg::ctrl_sts_t   sts,
    output drmu_pkg::out_item_t   result
);

    localparam int SW = drmu_pkg::SITE_W;
    localparam int LW = drmu_pkg::LEN_W;
    localparam int CW = drmu_pkg::COEF_W;
    localparam int TW = drmu_pkg::TERM_W;
    localparam int NT = drmu_pkg::TRIG_STAGES;
    localparam int NU = drmu_pkg::TERM_STAGES;

    drmu_pkg::in_item_t  item_reg;
    drmu_pkg::out_item_t result_reg;
    logic [15:0]         beta_reg;
    logic [LW-1:0]       rlen_reg;
    logic [LW-1:0]       len_c;

    // storage
    logic [15:0]   ang_a_mem [drmu_pkg::SITES];
    logic [15:0]   ang_b_mem [drmu_pkg::SITES];
    logic [CW-1:0] self_mem  [drmu_pkg::SITES];
    logic [CW-1:0] cz_mem    [drmu_pkg::SITES];
    logic [CW-1:0] cx_mem    [drmu_pkg::SITES];
    logic [15:0]   rd_a_reg, rd_b_reg;
    logic signed [CW-1:0] rd_s_reg, rd_z_reg, rd_x_reg;

    logic          load_ang_c, wb_c, ang_we_c, tab_we_c;
    logic [15:0]   ang_wdata_c;
    logic [SW-1:0] rd_addr_c, d_c, off_c, diff_c;
    logic [LW-1:0] alt_c, off_full_c;
    logic [15:0]   own_rd_c, other_rd_c, af_c;

    logic [15:0]   ai_reg, af_reg;
    logic          move_reg;

    // pipeline control and payload
    logic          v_mem_reg, se_mem_reg;
    logic [NT-1:0] tv_reg;
    logic          tk_reg [NT];
    logic          tse_reg [NT];
    logic signed [CW-1:0] ks_reg [NT];
    logic signed [CW-1:0] kz_reg [NT];
    logic signed [CW-1:0] kx_reg [NT];
    logic [NU-1:0] uv_reg;
    logic          use_reg [NU];
    logic          sv_reg;
    logic signed [31:0] sum_reg;
    logic signed [drmu_pkg::ACC_W-1:0] acc_reg;
    logic signed [16:0] dc_reg, ds_reg;

    logic [15:0]        ph_c [4];
    logic signed [15:0] lane_q [4];
    logic signed [TW-1:0] tq [4];
    logic signed [31:0] sum_c;
    logic signed [31:0] de_sat_c;

    // exp unit
    logic [46:0] x28_reg;
    logic [20:0] y_reg;
    logic        big_reg;
    logic [30:0] p_reg;
    logic        acc_flag_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_reg <= 16'd256;
            rlen_reg <= 7'd64;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                drmu_pkg::CFG_INV_TEMP: beta_reg <= cfg_data;
                drmu_pkg::CFG_RING_LEN: rlen_reg <= cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // clamped ring length
    always_comb
    begin
        if (rlen_reg < drmu_pkg::LEN_MIN)
        begin
            len_c = drmu_pkg::LEN_MIN;
        end
        else if (rlen_reg > drmu_pkg::LEN_MAX)
        begin
            len_c = drmu_pkg::LEN_MAX;
        end
        else
        begin
            len_c = rlen_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
    end

    // addresses: ring distance and cross offset for the swept site
    always_comb
    begin
        load_ang_c  = cmd.issue && (item_reg.func == drmu_pkg::FUNC_LOAD_ANGLE);
        wb_c        = cmd.wb && acc_flag_reg;
        ang_we_c    = load_ang_c || wb_c;
        ang_wdata_c = load_ang_c ? item_reg.angle : af_reg;
        tab_we_c    = cmd.issue && (item_reg.func == drmu_pkg::FUNC_LOAD_COEFF);
        rd_addr_c   = cmd.sweep ? cmd.idx : item_reg.site;

        diff_c = (cmd.idx > item_reg.site) ? (cmd.idx - item_reg.site)
                                           : (item_reg.site - cmd.idx);
        alt_c  = len_c - LW'(diff_c);
        d_c    = (alt_c < LW'(diff_c)) ? alt_c[SW-1:0] : diff_c;
        if (!item_reg.sublattice)
        begin
            off_full_c = (cmd.idx >= item_reg.site)
                       ? LW'(cmd.idx) - LW'(item_reg.site)
                       : LW'(cmd.idx) + len_c - LW'(item_reg.site);
        end
        else
        begin
            off_full_c = (item_reg.site >= cmd.idx)
                       ? LW'(item_reg.site) - LW'(cmd.idx)
                       : LW'(item_reg.site) + len_c - LW'(cmd.idx);
        end
        off_c = off_full_c[SW-1:0];
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (ang_we_c && !item_reg.sublattice)
        begin
            ang_a_mem[item_reg.site] <= ang_wdata_c;
        end
        if (ang_we_c && item_reg.sublattice)
        begin
            ang_b_mem[item_reg.site] <= ang_wdata_c;
        end
        rd_a_reg <= ang_a_mem[rd_addr_c];
        rd_b_reg <= ang_b_mem[rd_addr_c];
    end

    always_ff @(posedge clk)
    begin
        if (tab_we_c)
        begin
            self_mem[item_reg.coeff_index] <= item_reg.coeff_same;
            cz_mem[item_reg.coeff_index]   <= item_reg.coeff_cross_z;
            cx_mem[item_reg.coeff_index]   <= item_reg.coeff_cross_x;
        end
        rd_s_reg <= self_mem[d_c];
        rd_z_reg <= cz_mem[off_c];
        rd_x_reg <= cx_mem[off_c];
    end

    assign own_rd_c   = item_reg.sublattice ? rd_b_reg : rd_a_reg;
    assign other_rd_c = item_reg.sublattice ? rd_a_reg : rd_b_reg;
    assign af_c       = own_rd_c + item_reg.delta;

    // move set-up: old and new angle
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            ai_reg   <= own_rd_c;
            af_reg   <= af_c;
            move_reg <= sts.run_move;
        end
    end

    // trig lane inputs: old/new angle first, then own/other per site
    always_comb
    begin
        ph_c[0] = own_rd_c + drmu_pkg::QUARTER;
        ph_c[1] = own_rd_c;
        ph_c[2] = cmd.pre ? (af_c + drmu_pkg::QUARTER) : (other_rd_c + drmu_pkg::QUARTER);
        ph_c[3] = cmd.pre ? af_c : other_rd_c;
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        drmu_sin u_sin (
            .clk     (clk),
            .phase   (ph_c[g]),
            .sin_q15 (lane_q[g])
        );
    end

    // valid pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_mem_reg <= 1'b0;
            tv_reg    <= '0;
            uv_reg    <= '0;
            sv_reg    <= 1'b0;
        end
        else
        begin
            v_mem_reg <= cmd.sweep;
            tv_reg    <= {tv_reg[NT-2:0], v_mem_reg || cmd.pre};
            uv_reg    <= {uv_reg[NU-2:0], tv_reg[NT-1] && !tk_reg[NT-1]};
            sv_reg    <= uv_reg[NU-1];
        end
    end

    // payload alongside the trig and term lanes
    always_ff @(posedge clk)
    begin
        se_mem_reg <= (cmd.idx != item_reg.site);
        tk_reg[0]  <= cmd.pre;
        tse_reg[0] <= se_mem_reg;
        ks_reg[0]  <= rd_s_reg;
        kz_reg[0]  <= rd_z_reg;
        kx_reg[0]  <= rd_x_reg;
        for (int i = 1; i < NT; i++)
        begin
            tk_reg[i]  <= tk_reg[i-1];
            tse_reg[i] <= tse_reg[i-1];
            ks_reg[i]  <= ks_reg[i-1];
            kz_reg[i]  <= kz_reg[i-1];
            kx_reg[i]  <= kx_reg[i-1];
        end
        use_reg[0] <= tse_reg[NT-1];
        for (int i = 1; i < NU; i++)
        begin
            use_reg[i] <= use_reg[i-1];
        end
    end

    // cos/sin differences of the moved rotor
    always_ff @(posedge clk)
    begin
        if (tv_reg[NT-1] && tk_reg[NT-1])
        begin
            dc_reg <= 17'(lane_q[2]) - 17'(lane_q[0]);
            ds_reg <= 17'(lane_q[3]) - 17'(lane_q[1]);
        end
    end

    drmu_term u_term_sc (.clk(clk), .u(dc_reg), .v(lane_q[0]), .k(ks_reg[NT-1]), .t(tq[0]));
    drmu_term u_term_ss (.clk(clk), .u(ds_reg), .v(lane_q[1]), .k(ks_reg[NT-1]), .t(tq[1]));
    drmu_term u_term_cz (.clk(clk), .u(dc_reg), .v(lane_q[2]), .k(kz_reg[NT-1]), .t(tq[2]));
    drmu_term u_term_cx (.clk(clk), .u(ds_reg), .v(lane_q[3]), .k(kx_reg[NT-1]), .t(tq[3]));

    // per-site sum; ring A self bond weighs the sine part by -2
    always_comb
    begin
        if (!use_reg[NU-1])
        begin
            sum_c = 32'sd0;
        end
        else if (!item_reg.sublattice)
        begin
            sum_c = 32'(tq[0]) - (32'(tq[1]) <<< 1);
        end
        else
        begin
            sum_c = 32'(tq[0]) + 32'(tq[1]);
        end
        sum_c = sum_c + 32'(tq[2]) - 32'(tq[3]);
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_c;
        if (cmd.pre)
        begin
            acc_reg <= '0;
        end
        else if (sv_reg)
        begin
            acc_reg <= acc_reg + drmu_pkg::ACC_W'(sum_reg);
        end
    end

    // saturate to Q12.20
    always_comb
    begin
        if (acc_reg > 40'sd2147483647)
        begin
            de_sat_c = 32'sh7fffffff;
        end
        else if (acc_reg < -40'sd2147483648)
        begin
            de_sat_c = 32'sh80000000;
        end
        else
        begin
            de_sat_c = acc_reg[31:0];
        end
    end

    // exp(-dE*beta) one multiply per step, then the acceptance compare
    logic [34:0] xs_c;
    logic [36:0] ym_c;
    logic [30:0] pop_c;
    logic [46:0] pm_c;
    logic [30:0] pk_c;
    logic [5:0]  sh_c;
    logic [33:0] rnd_c, ev_c;
    logic [34:0] e2_c;

    always_comb
    begin
        xs_c  = x28_reg[46:12];
        ym_c  = 37'(xs_c[19:0]) * 37'(drmu_pkg::LOG2E) + 37'd32768;
        pop_c = (cmd.exp_step == drmu_pkg::EXP_P1) ? drmu_pkg::EXP_D : p_reg;
        pm_c  = 47'(pop_c) * 47'(y_reg[15:0]);
        case (cmd.exp_step)
            drmu_pkg::EXP_P1: pk_c = drmu_pkg::EXP_C;
            drmu_pkg::EXP_P2: pk_c = drmu_pkg::EXP_B;
            drmu_pkg::EXP_P3: pk_c = drmu_pkg::EXP_A;
            default:          pk_c = drmu_pkg::EXP_ONE;
        endcase
        sh_c  = 6'd15 + 6'(y_reg[20:16]);
        rnd_c = 34'd1 << (sh_c - 6'd1);
        ev_c  = big_reg ? 34'd0 : ((34'(p_reg) + rnd_c) >> sh_c);
        e2_c  = {ev_c, 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            acc_flag_reg <= 1'b0;
        end
        else if (cmd.exp_en)
        begin
            case (cmd.exp_step)
                drmu_pkg::EXP_MUL_BETA: x28_reg <= 47'(de_sat_c[30:0]) * 47'(beta_reg);
                drmu_pkg::EXP_LOG2:
                begin
                    y_reg   <= ym_c[36:16];
                    big_reg <= (xs_c >= drmu_pkg::EXP_XMAX);
                end
                drmu_pkg::EXP_P1,
                drmu_pkg::EXP_P2,
                drmu_pkg::EXP_P3,
                drmu_pkg::EXP_P4: p_reg <= pk_c - 31'(pm_c >> 16);
                drmu_pkg::EXP_FINAL:
                    acc_flag_reg <= (de_sat_c <= 32'sd0) || (35'(item_reg.uniform) < e2_c);
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            result_reg.accepted <= move_reg && acc_flag_reg;
            if (item_reg.func == drmu_pkg::FUNC_LOAD_ANGLE)
            begin
                result_reg.new_angle <= item_reg.angle;
            end
            else if (move_reg && acc_flag_reg)
            begin
                result_reg.new_angle <= af_reg;
            end
            else
            begin
                result_reg.new_angle <= ai_reg;
            end
            result_reg.energy_change <= move_reg ? de_sat_c : 32'sd0;
        end
    end

    assign result = result_reg;

    // status
    always_comb
    begin
        sts.run_move   = (item_reg.func == drmu_pkg::FUNC_MOVE)
                      && (LW'(item_reg.site) < len_c);
        sts.pipe_busy  = v_mem_reg || (|tv_reg) || (|uv_reg) || sv_reg;
        sts.sweep_last = (LW'(cmd.idx) == (len_c - 7'd1));
        sts.idx_ok     = (LW'(cmd.idx) < len_c);
    end

endmodule
`default_nettype wire

// ----- hdl/drmu_ctrl.sv -----
// Controller state machine: sequences loads, the site sweep, exp and result.
// Depends on drmu_pkg and the assertion macro header.
`default_nettype none
`include "dipolar_rotor_metropolis_update_macros.svh"
module drmu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    output logic                result_valid,
    input  logic                result_stall,
    input  drmu_pkg::ctrl_sts_t sts,
    output drmu_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ISSUE = 9'b000000010,
        S_LATCH = 9'b000000100,
        S_PREW  = 9'b000001000,
        S_SWEEP = 9'b000010000,
        S_DRAIN = 9'b000100000,
        S_EXP   = 9'b001000000,
        S_WB    = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [drmu_pkg::SITE_W-1:0] idx_reg, idx_next;
    logic [2:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;

    // commands
    always_comb
    begin
        cmd          = '0;
        cmd.capture  = (state_reg == S_IDLE) && item_valid;
        cmd.issue    = (state_reg == S_ISSUE);
        cmd.latch    = (state_reg == S_LATCH);
        cmd.pre      = (state_reg == S_LATCH) && sts.run_move;
        cmd.sweep    = (state_reg == S_SWEEP);
        cmd.idx      = idx_reg;
        cmd.exp_en   = (state_reg == S_EXP);
        cmd.exp_step = drmu_pkg::exp_step_t'(cnt_reg);
        cmd.wb       = (state_reg == S_WB);
        cmd.load_out = (state_reg == S_OUT) && (!out_valid_reg || !result_stall);
    end

    // next state
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && result_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE: state_next = S_LATCH;
            S_LATCH: state_next = sts.run_move ? S_PREW : S_OUT;
            S_PREW:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = S_SWEEP;
                    idx_next   = '0;
                end
            end
            S_SWEEP:
            begin
                if (sts.sweep_last)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 6'd1;
                end
            end
            S_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = S_EXP;
                    cnt_next   = 3'(drmu_pkg::EXP_MUL_BETA);
                end
            end
            S_EXP:
            begin
                if (cnt_reg == 3'(drmu_pkg::EXP_FINAL))
                begin
                    state_next = S_WB;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            S_WB: state_next = S_OUT;
            S_OUT:
            begin
                if (cmd.load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;

    // checks
    `DRMU_ASSERT_NEXT(a_accept_starts, item_valid && !item_stall, state_reg == S_ISSUE)
    `DRMU_ASSERT_NOW(a_sweep_in_range, state_reg == S_SWEEP, sts.idx_ok)
    `DRMU_ASSERT_NEXT(a_last_drains, (state_reg == S_SWEEP) && sts.sweep_last, state_reg == S_DRAIN)
    `DRMU_ASSERT_NEXT(a_load_shows, cmd.load_out, result_valid)

endmodule
`default_nettype wire
